>>> hdl/uftl_pkg.sv
// ----------------------------------------------------------------------------
// uftl_pkg
// Shared constants for the serial frame collector and word-table loader.
// ----------------------------------------------------------------------------
`default_nettype none

package uftl_pkg;

    // Default sizes of the frame buffer and of the word table.
    localparam int DEF_MAX_FRAME_BYTES   = 400;
    localparam int DEF_CHANNELS          = 4;
    localparam int DEF_WORDS_PER_CHANNEL = 20;

    // Frame delimiters and marker values.
    localparam logic [7:0] HEAD0      = 8'hEB;
    localparam logic [7:0] HEAD1      = 8'h90;
    localparam logic [7:0] TAIL0      = 8'h0A;
    localparam logic [7:0] TAIL1      = 8'h0D;
    localparam logic [7:0] TERMINATOR = 8'hFF;

    // Frame layout: channel c has its marker at MARK_OFFSET + STRIDE * c,
    // its first word byte one later and its terminator TERM_DIST after the marker.
    localparam int STRIDE      = 82;
    localparam int MARK_OFFSET = 2;
    localparam int LOAD_OFFSET = 3;
    localparam int TERM_DIST   = 81;
    localparam int BYTES_PER_WORD = 4;

    // Width of a table index formed from a 2-bit channel and a 5-bit word index.
    localparam int TBL_IDX_FULL_W = 7;

    // Item kinds on the input stream.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

`default_nettype wire

>>> hdl/uart_frame_table_loader.sv
// ----------------------------------------------------------------------------
// uart_frame_table_loader
// Collects serial bytes into frames and loads a big-endian word table from valid ones.
// A frame end walks the marker and terminator checks and, if all pass, loads the table;
// a read item returns the table word. One item is handled at a time: the input is
// not ready again until the last result has gone into the output register, which a
// stalled result delays.
// Reset clears the byte count, the buffer id and the table valid bits (table reads 0).
// ----------------------------------------------------------------------------
`default_nettype none

module uart_frame_table_loader #(
    parameter int MAX_FRAME_BYTES   = uftl_pkg::DEF_MAX_FRAME_BYTES,
    parameter int CHANNELS          = uftl_pkg::DEF_CHANNELS,
    parameter int WORDS_PER_CHANNEL = uftl_pkg::DEF_WORDS_PER_CHANNEL
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // rx_byte[7:0], read_channel[9:8],
                                              // read_index[14:10], zero[15]
    input  wire logic        i_s_axis_tuser,  // req_type[0]
    // Result items.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // read_word[31:0]
    output logic [1:0]       o_m_axis_tuser,  // frame_valid[0], frame_buffer_id[1]
    output logic             o_m_axis_tlast   // frame_end
);

    // Derived sizes.
    localparam int FB_AW     = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int TBL_DEPTH = CHANNELS * WORDS_PER_CHANNEL;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = (WORDS_PER_CHANNEL > 1) ? $clog2(WORDS_PER_CHANNEL) : 1;
    localparam int LAST_TERM = uftl_pkg::MARK_OFFSET + uftl_pkg::TERM_DIST
                               + uftl_pkg::STRIDE * (CHANNELS - 1);
    localparam int CH_END_STEP = uftl_pkg::STRIDE
                                 - uftl_pkg::BYTES_PER_WORD * WORDS_PER_CHANNEL + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    // Input item fields.
    logic       in_req_type;
    logic [7:0] in_rx_byte;
    logic [1:0] in_read_channel;
    logic [4:0] in_read_index;

    assign in_req_type     = i_s_axis_tuser;
    assign in_rx_byte      = i_s_axis_tdata[7:0];
    assign in_read_channel = i_s_axis_tdata[9:8];
    assign in_read_index   = i_s_axis_tdata[14:10];

    // Control and datapath registers.
    logic [2:0]           r_state, n_state;
    logic                 r_ph, n_ph;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [7:0]           r_prev, n_prev;
    logic                 r_buf, n_buf;
    logic [FB_AW-1:0]     r_addr, n_addr;
    logic [CH_W-1:0]      r_chan, n_chan;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [1:0]           r_b, n_b;
    logic                 r_term, n_term;
    logic [TBL_AW-1:0]    r_tidx, n_tidx;
    logic [23:0]          r_word, n_word;
    logic                 r_rd_ok, n_rd_ok;
    logic [TBL_DEPTH-1:0] r_tvalid, n_tvalid;

    // Pending result.
    logic        r_res_end, n_res_end;
    logic        r_res_valid, n_res_valid;
    logic        r_res_buf, n_res_buf;
    logic [31:0] r_res_word, n_res_word;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic        r_out_end, n_out_end;
    logic        r_out_fvalid, n_out_fvalid;
    logic        r_out_buf, n_out_buf;
    logic [31:0] r_out_word, n_out_word;

    // RAM ports.
    logic              fb_we;
    logic              fb_re;
    logic [7:0]        fb_rdata;
    logic              tb_we;
    logic              tb_re;
    logic [TBL_AW-1:0] tb_raddr;
    logic [31:0]       tb_wdata;
    logic [31:0]       tb_rdata;

    // Byte-item decode.
    logic                      accept;
    logic [CNT_W-1:0]          count_inc;
    logic                      bad_hdr;
    logic                      tail;
    logic                      rd_in_range;
    logic [uftl_pkg::TBL_IDX_FULL_W-1:0] rd_idx_full;
    logic [TBL_AW-1:0]         rd_idx;

    // Shared address adder and compare.
    logic [FB_AW-1:0] step_sel;
    logic [FB_AW-1:0] addr_sum;
    logic [7:0]       expect_byte;
    logic             byte_match;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    assign count_inc = r_count + CNT_W'(1);
    assign bad_hdr   = (r_count == CNT_W'(1))
                       && ((r_prev != uftl_pkg::HEAD0) || (in_rx_byte != uftl_pkg::HEAD1));
    assign tail      = (r_count != '0) && !bad_hdr
                       && (r_prev == uftl_pkg::TAIL0) && (in_rx_byte == uftl_pkg::TAIL1);

    // Table read index: channel times words per channel plus word index.
    assign rd_in_range = (3'(in_read_channel) < 3'(CHANNELS))
                         && (6'(in_read_index) < 6'(WORDS_PER_CHANNEL));
    assign rd_idx_full = uftl_pkg::TBL_IDX_FULL_W'(in_read_channel)
                         * uftl_pkg::TBL_IDX_FULL_W'(WORDS_PER_CHANNEL)
                         + uftl_pkg::TBL_IDX_FULL_W'(in_read_index);
    assign rd_idx      = rd_idx_full[TBL_AW-1:0];

    // Step for the shared adder, chosen by the scan position.
    always_comb begin
        step_sel = FB_AW'(1);
        if (r_state == S_CHK && !r_term) begin
            step_sel = FB_AW'(uftl_pkg::TERM_DIST);
        end else if (r_state == S_LOAD && r_b == 2'd3
                     && r_k == IDX_W'(WORDS_PER_CHANNEL - 1)) begin
            step_sel = FB_AW'(CH_END_STEP);
        end
    end

    assign addr_sum    = r_addr + step_sel;
    assign expect_byte = r_term ? uftl_pkg::TERMINATOR : (8'(r_chan) + 8'd1);
    assign byte_match  = (fb_rdata == expect_byte);

    // RAM control.
    assign fb_we    = accept && (in_req_type == uftl_pkg::REQ_BYTE);
    assign fb_re    = ((r_state == S_CHK) || (r_state == S_LOAD)) && !r_ph;
    assign tb_we    = (r_state == S_LOAD) && r_ph && (r_b == 2'd3);
    assign tb_wdata = {r_word, fb_rdata};
    assign tb_re    = accept && (in_req_type == uftl_pkg::REQ_READ);
    assign tb_raddr = rd_idx;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_ph         = r_ph;
        n_count      = r_count;
        n_prev       = r_prev;
        n_buf        = r_buf;
        n_addr       = r_addr;
        n_chan       = r_chan;
        n_k          = r_k;
        n_b          = r_b;
        n_term       = r_term;
        n_tidx       = r_tidx;
        n_word       = r_word;
        n_rd_ok      = r_rd_ok;
        n_tvalid     = r_tvalid;
        n_res_end    = r_res_end;
        n_res_valid  = r_res_valid;
        n_res_buf    = r_res_buf;
        n_res_word   = r_res_word;
        n_out_valid  = r_out_valid;
        n_out_end    = r_out_end;
        n_out_fvalid = r_out_fvalid;
        n_out_buf    = r_out_buf;
        n_out_word   = r_out_word;

        // Output register drains independently of the sequencer.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_end   = 1'b0;
                    n_res_valid = 1'b0;
                    n_res_buf   = 1'b0;
                    n_res_word  = '0;
                    if (in_req_type == uftl_pkg::REQ_READ) begin
                        n_rd_ok = rd_in_range && r_tvalid[rd_idx];
                        n_state = S_RDWAIT;
                    end else begin
                        n_prev = in_rx_byte;
                        if (tail) begin
                            // Frame end: report it and walk the checks if long enough.
                            n_count   = '0;
                            n_res_end = 1'b1;
                            n_res_buf = r_buf;
                            n_buf     = !r_buf;
                            n_ph      = 1'b0;
                            n_term    = 1'b0;
                            n_chan    = '0;
                            n_addr    = FB_AW'(uftl_pkg::MARK_OFFSET);
                            if (count_inc > CNT_W'(LAST_TERM)) begin
                                n_state = S_CHK;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end else begin
                            if (bad_hdr || count_inc == CNT_W'(MAX_FRAME_BYTES)) begin
                                n_count = '0;
                            end else begin
                                n_count = count_inc;
                            end
                            n_state = S_EMIT;
                        end
                    end
                end
            end

            S_RDWAIT: begin
                n_res_word = r_rd_ok ? tb_rdata : '0;
                n_state    = S_EMIT;
            end

            S_CHK: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    if (!byte_match) begin
                        n_state = S_EMIT;
                    end else if (!r_term) begin
                        n_addr = addr_sum;
                        n_term = 1'b1;
                    end else if (r_chan == CH_W'(CHANNELS - 1)) begin
                        // All markers good: start loading at the first word byte.
                        n_addr  = FB_AW'(uftl_pkg::LOAD_OFFSET);
                        n_chan  = '0;
                        n_k     = '0;
                        n_b     = '0;
                        n_tidx  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_addr = addr_sum;
                        n_chan = r_chan + CH_W'(1);
                        n_term = 1'b0;
                    end
                end
            end

            S_LOAD: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    n_word = {r_word[15:0], fb_rdata};
                    n_b    = r_b + 2'd1;
                    n_addr = addr_sum;
                    if (r_b == 2'd3) begin
                        n_tvalid[r_tidx] = 1'b1;
                        n_tidx = r_tidx + TBL_AW'(1);
                        if (r_k == IDX_W'(WORDS_PER_CHANNEL - 1)) begin
                            n_k = '0;
                            if (r_chan == CH_W'(CHANNELS - 1)) begin
                                n_res_valid = 1'b1;
                                n_state     = S_EMIT;
                            end else begin
                                n_chan = r_chan + CH_W'(1);
                            end
                        end else begin
                            n_k = r_k + IDX_W'(1);
                        end
                    end
                end
            end

            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_end    = r_res_end;
                    n_out_fvalid = r_res_valid;
                    n_out_buf    = r_res_buf;
                    n_out_word   = r_res_word;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= 1'b0;
            r_count     <= '0;
            r_buf       <= 1'b0;
            r_tvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_count     <= n_count;
            r_buf       <= n_buf;
            r_tvalid    <= n_tvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge i_clk) begin
        r_prev       <= n_prev;
        r_addr       <= n_addr;
        r_chan       <= n_chan;
        r_k          <= n_k;
        r_b          <= n_b;
        r_term       <= n_term;
        r_tidx       <= n_tidx;
        r_word       <= n_word;
        r_rd_ok      <= n_rd_ok;
        r_res_end    <= n_res_end;
        r_res_valid  <= n_res_valid;
        r_res_buf    <= n_res_buf;
        r_res_word   <= n_res_word;
        r_out_end    <= n_out_end;
        r_out_fvalid <= n_out_fvalid;
        r_out_buf    <= n_out_buf;
        r_out_word   <= n_out_word;
    end

    // Frame byte buffer.
    uftl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (r_count[FB_AW-1:0]),
        .i_wdata (in_rx_byte),
        .i_re    (fb_re),
        .i_raddr (r_addr),
        .o_rdata (fb_rdata)
    );

    // Word table.
    uftl_ram #(
        .WIDTH (32),
        .DEPTH (TBL_DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (r_tidx),
        .i_wdata (tb_wdata),
        .i_re    (tb_re),
        .i_raddr (tb_raddr),
        .o_rdata (tb_rdata)
    );

    // Ports.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = {r_out_buf, r_out_fvalid};
    assign o_m_axis_tlast  = r_out_end;

endmodule

`default_nettype wire

>>> hdl/uftl_ram.sv
// ----------------------------------------------------------------------------
// uftl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module uftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the serial frame collector and word-table loader.
// A short table of directed items covers the header, tail and read corner
// cases. Random traffic then follows, made mostly of well-formed frames with
// random word data. It also holds cut frames, frames with one bad marker or
// terminator, overlong frames, broken headers, loose bytes and table reads.
// Results are checked against a predictor in this bench or a typed-in expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES   = uftl_pkg::DEF_MAX_FRAME_BYTES;
    localparam int NUM_CHAN    = uftl_pkg::DEF_CHANNELS;
    localparam int NUM_WORDS   = uftl_pkg::DEF_WORDS_PER_CHANNEL;
    localparam int TABLE_WORDS = NUM_CHAN * NUM_WORDS;
    localparam int FULL_LEN    = uftl_pkg::MARK_OFFSET + uftl_pkg::STRIDE * (NUM_CHAN - 1)
                                 + uftl_pkg::TERM_DIST + 3;
    localparam int ITEMS_TOTAL = 1750;
    localparam int QUIET_ITEMS = 250;
    localparam int DRAIN_CYCLES = 700;
    localparam int NUM_DIR     = 24;
    localparam int MAX_PRINTS  = 40;

    // One result item: frame end, frame check outcome, buffer slot, table word.
    typedef struct packed {
        logic        frame_end;
        logic        frame_valid;
        logic        buf_id;
        logic [31:0] word;
    } t_result;

    // One row of directed stimulus, with an optional typed-in expectation.
    typedef struct packed {
        logic        req;
        logic [7:0]  rx;
        logic [1:0]  ch;
        logic [4:0]  idx;
        logic        typed;
        logic        fe;
        logic        fv;
        logic        fid;
        logic [31:0] word;
    } t_dir_row;

    // Kinds of random traffic sequences.
    typedef enum int {
        SEQ_GOOD,
        SEQ_CORRUPT,
        SEQ_CUT,
        SEQ_LONG,
        SEQ_BAD_HEAD,
        SEQ_READS,
        SEQ_NOISE,
        SEQ_KINDS
    } t_seq_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Predictor state of the frame collector and the word table.
    int unsigned rx_cnt;
    logic        buf_sel;
    logic [7:0]  rx_mem [0:MAX_BYTES-1];
    logic [31:0] word_tbl [0:TABLE_WORDS-1];

    t_result     pending_q [$];
    int          err_cnt = 0;
    int          item_cnt = 0;
    bit          quiet = 1'b0;
    t_dir_row    dir_tbl [NUM_DIR];

    uart_frame_table_loader dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    // Clock with a 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predict the result of one accepted item and advance the predictor state.
    function automatic t_result frame_table_step(input logic req, input logic [7:0] rx,
                                                 input logic [1:0] ch,
                                                 input logic [4:0] idx);
        t_result     r;
        int unsigned len;
        int          c;
        int          k;
        int          mark;
        int          term;
        int          p;
        bit          ok;
        r = '0;
        if (req == uftl_pkg::REQ_READ) begin
            if (ch < NUM_CHAN && idx < NUM_WORDS)
                r.word = word_tbl[ch * NUM_WORDS + idx];
            return r;
        end
        if (rx_cnt >= MAX_BYTES)
            rx_cnt = 0;
        rx_mem[rx_cnt] = rx;
        rx_cnt++;
        // A wrong header byte in either position drops the frame silently.
        if (rx_cnt == 2 && (rx_mem[0] != uftl_pkg::HEAD0 || rx_mem[1] != uftl_pkg::HEAD1))
            rx_cnt = 0;
        if (rx_cnt >= 2 && rx_mem[rx_cnt-1] == uftl_pkg::TAIL1
            && rx_mem[rx_cnt-2] == uftl_pkg::TAIL0) begin
            len = rx_cnt;
            rx_cnt = 0;
            r.frame_end = 1'b1;
            r.buf_id = buf_sel;
            ok = 1'b1;
            // Markers and terminators must lie inside this frame and match.
            for (c = 0; c < NUM_CHAN; c++) begin
                mark = uftl_pkg::MARK_OFFSET + uftl_pkg::STRIDE * c;
                term = mark + uftl_pkg::TERM_DIST;
                if (term >= len || mark >= len)
                    ok = 1'b0;
                else if (rx_mem[mark] != 8'(c + 1) || rx_mem[term] != uftl_pkg::TERMINATOR)
                    ok = 1'b0;
            end
            if (ok) begin
                for (c = 0; c < NUM_CHAN; c++) begin
                    for (k = 0; k < NUM_WORDS; k++) begin
                        p = uftl_pkg::LOAD_OFFSET + uftl_pkg::STRIDE * c
                            + uftl_pkg::BYTES_PER_WORD * k;
                        word_tbl[c * NUM_WORDS + k] =
                            {rx_mem[p], rx_mem[p+1], rx_mem[p+2], rx_mem[p+3]};
                    end
                end
                r.frame_valid = 1'b1;
            end
            buf_sel = ~buf_sel;
        end else if (rx_cnt >= MAX_BYTES) begin
            rx_cnt = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one item at a falling edge, hold it until accepted, then predict.
    task automatic push_item(input logic req, input logic [7:0] rx, input logic [1:0] ch,
                             input logic [4:0] idx, input bit typed,
                             input t_result typed_res);
        t_result r;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, ch, rx};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        r = frame_table_step(req, rx, ch, idx);
        pending_q.push_back(typed ? typed_res : r);
        item_cnt++;
        if (item_cnt >= ITEMS_TOTAL - QUIET_ITEMS)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(uftl_pkg::REQ_BYTE, b, 2'($urandom_range(0, 3)),
                  5'($urandom_range(0, 31)), 1'b0, '0);
    endtask

    // Reads mostly hit the table; some use an index past the end of a channel.
    task automatic send_read();
        logic [4:0] idx;
        idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(NUM_WORDS, 31))
                                          : 5'($urandom_range(0, NUM_WORDS - 1));
        push_item(uftl_pkg::REQ_READ, 8'($urandom), 2'($urandom_range(0, 3)), idx,
                  1'b0, '0);
    endtask

    // Bring the collector back to an empty frame before a structured sequence.
    task automatic flush_frame();
        while (rx_cnt != 0) begin
            if (rx_cnt == 1)
                send_byte(8'h00);
            else
                send_byte(rx_mem[rx_cnt-1] == uftl_pkg::TAIL0 ? uftl_pkg::TAIL1
                                                              : uftl_pkg::TAIL0);
        end
    endtask

    // Send a framed byte run of length flen with random word data. bad_pos,
    // when not negative, names a check position to spoil. Without a tail the
    // run simply overflows the buffer.
    task automatic send_frame(input int flen, input int bad_pos, input bit with_tail);
        logic [7:0] frm [0:MAX_BYTES-1];
        int         i;
        int         c;
        int         last;
        for (i = 0; i < MAX_BYTES; i++)
            frm[i] = 8'($urandom);
        frm[0] = uftl_pkg::HEAD0;
        frm[1] = uftl_pkg::HEAD1;
        for (c = 0; c < NUM_CHAN; c++) begin
            frm[uftl_pkg::MARK_OFFSET + uftl_pkg::STRIDE * c] = 8'(c + 1);
            frm[uftl_pkg::MARK_OFFSET + uftl_pkg::STRIDE * c + uftl_pkg::TERM_DIST] =
                uftl_pkg::TERMINATOR;
        end
        if (bad_pos >= 0)
            frm[bad_pos] = frm[bad_pos] ^ 8'($urandom_range(1, 255));
        if (with_tail) begin
            frm[flen-2] = uftl_pkg::TAIL0;
            frm[flen-1] = uftl_pkg::TAIL1;
        end
        // Keep the tail pattern out of the body so the frame ends where planned.
        last = with_tail ? flen - 2 : flen - 1;
        for (i = 1; i <= last; i++) begin
            if (frm[i-1] == uftl_pkg::TAIL0 && frm[i] == uftl_pkg::TAIL1)
                frm[i] = 8'h0C;
        end
        for (i = 0; i < flen; i++) begin
            if ($urandom_range(0, 39) == 0)
                send_read();
            send_byte(frm[i]);
        end
    endtask

    // Loose bytes, leaning toward the delimiter values.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return uftl_pkg::HEAD0;
            1: return uftl_pkg::HEAD1;
            2: return uftl_pkg::TAIL0;
            3: return uftl_pkg::TAIL1;
            4: return uftl_pkg::TERMINATOR;
            default: return 8'($urandom);
        endcase
    endfunction

    // Result side: ready with random stall bursts, steady in the last part.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 32'h0);
            end else begin
                want = pending_q.pop_front();
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", 32'(m_tlast), 32'(want.frame_end));
                if (m_tuser[0] !== want.frame_valid)
                    report_mismatch("frame_valid", 32'(m_tuser[0]), 32'(want.frame_valid));
                if (m_tuser[1] !== want.buf_id)
                    report_mismatch("frame_buffer_id", 32'(m_tuser[1]), 32'(want.buf_id));
                if (m_tdata !== want.word)
                    report_mismatch("read_word", m_tdata, want.word);
            end
        end
    end

    // Stimulus: reset, directed rows, random sequences, then drain.
    initial begin
        t_dir_row  row;
        t_seq_kind kind;
        int        seq_no;
        int        i;
        int        r;
        int        c;

        rx_cnt = 0;
        buf_sel = 1'b0;
        for (i = 0; i < TABLE_WORDS; i++)
            word_tbl[i] = '0;

        // Reads after reset and at the field extremes, broken headers on
        // either byte, a tail that comes before any frame, and two short
        // frames that end without their markers.
        dir_tbl = '{
            '{uftl_pkg::REQ_READ, 8'h00, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_READ, 8'hFF, 2'd3, 5'd19, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_READ, 8'h00, 2'd3, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'hFF, 2'd3, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h00, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'hEB, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h00, 2'd1, 5'd7,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h00, 2'd2, 5'd9,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h90, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0A, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0D, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'hEB, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h90, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0A, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0D, 2'd0, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'hEB, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h90, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h01, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0A, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h0D, 2'd0, 5'd0,  1'b1, 1'b1, 1'b0, 1'b1, 32'h0},
            '{uftl_pkg::REQ_READ, 8'h00, 2'd1, 5'd5,  1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_READ, 8'h00, 2'd0, 5'd20, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_READ, 8'h00, 2'd2, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
            '{uftl_pkg::REQ_BYTE, 8'h5A, 2'd1, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0}
        };

        // Synchronous reset, released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < NUM_DIR; i++) begin
            row = dir_tbl[i];
            push_item(row.req, row.rx, row.ch, row.idx, row.typed,
                      '{row.fe, row.fv, row.fid, row.word});
        end

        // Random sequences: one of each kind first, then good frames more often than any other kind.
        seq_no = 0;
        while (item_cnt < ITEMS_TOTAL) begin
            if (seq_no < SEQ_KINDS) begin
                kind = t_seq_kind'(seq_no);
            end else begin
                r = $urandom_range(0, 11);
                kind = (r <= 3) ? SEQ_GOOD :
                       (r == 4) ? SEQ_CORRUPT :
                       (r == 5) ? SEQ_CUT :
                       (r == 6) ? SEQ_LONG :
                       (r <= 8) ? SEQ_BAD_HEAD :
                       (r <= 10) ? SEQ_READS : SEQ_NOISE;
            end
            if (kind != SEQ_NOISE && kind != SEQ_READS)
                flush_frame();
            case (kind)
                SEQ_GOOD: begin
                    send_frame(($urandom_range(0, 3) == 0) ?
                               $urandom_range(FULL_LEN + 1, MAX_BYTES) : FULL_LEN,
                               -1, 1'b1);
                end
                SEQ_CORRUPT: begin
                    c = $urandom_range(0, NUM_CHAN - 1);
                    send_frame(FULL_LEN, uftl_pkg::MARK_OFFSET + uftl_pkg::STRIDE * c +
                               ($urandom_range(0, 1) ? uftl_pkg::TERM_DIST : 0), 1'b1);
                end
                SEQ_CUT: begin
                    send_frame(($urandom_range(0, 1) == 0) ? $urandom_range(4, 12)
                                                           : $urandom_range(4, FULL_LEN - 1),
                               -1, 1'b1);
                end
                SEQ_LONG: begin
                    send_frame(MAX_BYTES, -1, 1'b0);
                end
                SEQ_BAD_HEAD: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            send_byte(uftl_pkg::HEAD0);
                            send_byte(uftl_pkg::HEAD1 ^ 8'($urandom_range(1, 255)));
                        end
                        1: begin
                            send_byte(uftl_pkg::HEAD0 ^ 8'($urandom_range(1, 255)));
                            send_byte(uftl_pkg::HEAD1);
                        end
                        default: begin
                            send_byte(noise_byte());
                            send_byte(noise_byte());
                        end
                    endcase
                end
                SEQ_READS: begin
                    repeat ($urandom_range(1, 16)) send_read();
                end
                default: begin
                    repeat ($urandom_range(1, 20)) send_byte(noise_byte());
                end
            endcase
            seq_no++;
        end
        s_tvalid <= 1'b0;

        // Drain and give a late or extra result time to show up.
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
